### design/ocm_pkg.sv
// ----------------------------------------------------------------------------
// ocm_pkg
// shared constants and types of the ofdm carrier mapper
// ----------------------------------------------------------------------------
`default_nettype none

package ocm_pkg;

  // default sizes
  localparam int DEF_MAX_FFT_LEN = 64;
  localparam int DEF_MAX_SETS    = 4;

  // fixed field widths
  localparam int SAMPLE_W  = 16;
  localparam int FFT_W     = 7;
  localparam int SETS_W    = 3;
  localparam int BIN_NUM_W = 6;
  localparam int TSET_W    = 2;
  localparam int SLOT_W    = 6;
  localparam int CIDX_W    = 7;
  localparam int REG_IDX_W = 3;
  localparam int CFG_W     = 7;
  localparam int CSET_W    = 2;
  localparam int NUM_SIZES = 4;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_FFT_LEN    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_NUM_SETS   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SET_SIZE_0 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SET_SIZE_1 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SET_SIZE_2 = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SET_SIZE_3 = 3'd5;

  // register reset values
  localparam logic [FFT_W-1:0]  RST_FFT_LEN  = 7'd64;
  localparam logic [SETS_W-1:0] RST_NUM_SETS = 3'd1;
  localparam logic [FFT_W-1:0]  RST_SET_SIZE = 7'd48;

  // item kinds
  localparam logic FUNC_DATA  = 1'b0;
  localparam logic FUNC_TABLE = 1'b1;

  // requests from the sequencer to the frame store
  typedef struct packed {
    logic                        wr_en;
    logic [BIN_NUM_W-1:0]        wr_bin;
    logic [2*SAMPLE_W-1:0]       wr_data;
    logic                        emit_start;
    logic [FFT_W-1:0]            emit_len;
    logic                        emit_eop;
    logic                        rej_load;
  } frame_cmd_t;

  // frame store status back to the sequencer
  typedef struct packed {
    logic emitting;
    logic fetch_free;
  } frame_stat_t;

endpackage

`default_nettype wire

### design/ofdm_carrier_mapper.sv
// ----------------------------------------------------------------------------
// ofdm_carrier_mapper
// places complex samples on ofdm bins through a loadable carrier table
// ----------------------------------------------------------------------------
//  channel   signals                              dir   per beat
//  in        in_valid/in_ready + item fields      in    one sample or table write
//  out       out_valid/out_ready + bin fields     out   one bin or one status
//  cfg       cfg_write, cfg_index, cfg_data       in    one register write
//
//  a table write passes the process state; a rejected one then waits in the reject
//  state until its status beat enters the readout stage
//  a sample: carrier table read on accept, frame store write next
//  a sample that closes a symbol then holds off input while the frame store is read
//  out, bin by bin over the clamped fft_len bins; a stalled out channel stretches this
//  reset clears control state and the frame store valid bits;
//  the carrier table is not cleared and has no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module ofdm_carrier_mapper #(
  parameter int MAX_FFT_LEN = ocm_pkg::DEF_MAX_FFT_LEN,
  parameter int MAX_SETS    = ocm_pkg::DEF_MAX_SETS
) (
  input  wire                                    clk,
  input  wire                                    rst,
  // configuration
  input  wire                                    cfg_write,
  input  wire         [ocm_pkg::REG_IDX_W-1:0]   cfg_index,
  input  wire         [ocm_pkg::CFG_W-1:0]       cfg_data,
  // input items
  input  wire                                    in_valid,
  output logic                                   in_ready,
  input  wire                                    func,
  input  wire  signed [ocm_pkg::SAMPLE_W-1:0]    sample_re,
  input  wire  signed [ocm_pkg::SAMPLE_W-1:0]    sample_im,
  input  wire                                    end_of_packet,
  input  wire         [ocm_pkg::TSET_W-1:0]      table_set,
  input  wire         [ocm_pkg::SLOT_W-1:0]      table_slot,
  input  wire  signed [ocm_pkg::CIDX_W-1:0]      carrier_index,
  // result items
  output logic                                   out_valid,
  input  wire                                    out_ready,
  output logic signed [ocm_pkg::SAMPLE_W-1:0]    bin_re,
  output logic signed [ocm_pkg::SAMPLE_W-1:0]    bin_im,
  output logic        [ocm_pkg::BIN_NUM_W-1:0]   bin_number,
  output logic                                   last_bin,
  output logic                                   packet_done,
  output logic                                   status
);

  localparam int BIN_W     = $clog2(MAX_FFT_LEN);
  localparam int TBL_DEPTH = MAX_SETS * MAX_FFT_LEN;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);
  localparam int SETS_LIM  = (MAX_SETS < 4) ? MAX_SETS : 4;

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PROC = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;
  localparam logic [1:0] ST_REJ  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // configuration registers
  logic [ocm_pkg::FFT_W-1:0]  fft_len;
  logic [ocm_pkg::SETS_W-1:0] num_sets;
  logic [ocm_pkg::FFT_W-1:0]  set_size [ocm_pkg::NUM_SIZES];

  // held input beat
  logic                                item_func;
  logic [2*ocm_pkg::SAMPLE_W-1:0]      item_data;
  logic                                item_eop;
  logic [ocm_pkg::TSET_W-1:0]          item_set;
  logic [ocm_pkg::SLOT_W-1:0]          item_slot;
  logic signed [ocm_pkg::CIDX_W-1:0]   item_cidx;

  // mapping state
  logic [ocm_pkg::CSET_W-1:0] current_set;
  logic [ocm_pkg::CSET_W-1:0] current_set_next;
  logic [ocm_pkg::FFT_W-1:0]  filled_count;

  // carrier table
  logic [BIN_W-1:0]  tbl_mem [TBL_DEPTH];
  logic [BIN_W-1:0]  tbl_rdata;
  logic [TBL_AW-1:0] tbl_raddr;
  logic [TBL_AW-1:0] tbl_waddr;
  logic              tbl_we;

  // derived values
  logic [ocm_pkg::FFT_W-1:0]  eff_fft;
  logic [ocm_pkg::SETS_W-1:0] eff_sets;
  logic [ocm_pkg::FFT_W-1:0]  size_raw;
  logic [ocm_pkg::FFT_W-1:0]  eff_size;
  logic [ocm_pkg::FFT_W-1:0]  fc_inc;
  logic                       fc_in_range;
  logic                       bin_ok;
  logic                       emit_now;
  logic signed [ocm_pkg::CIDX_W:0] wrapped;
  logic                       reject;

  logic                 in_fire;
  ocm_pkg::frame_cmd_t  fcmd;
  ocm_pkg::frame_stat_t fstat;

  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  // register writes: the user keeps them to only while idle; the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      fft_len  <= ocm_pkg::RST_FFT_LEN;
      num_sets <= ocm_pkg::RST_NUM_SETS;
      for (int i = 0; i < ocm_pkg::NUM_SIZES; i++) begin
        set_size[i] <= ocm_pkg::RST_SET_SIZE;
      end
    end else if (cfg_write) begin
      unique case (cfg_index)
        ocm_pkg::REG_FFT_LEN:    fft_len     <= cfg_data;
        ocm_pkg::REG_NUM_SETS:   num_sets    <= cfg_data[ocm_pkg::SETS_W-1:0];
        ocm_pkg::REG_SET_SIZE_0: set_size[0] <= cfg_data;
        ocm_pkg::REG_SET_SIZE_1: set_size[1] <= cfg_data;
        ocm_pkg::REG_SET_SIZE_2: set_size[2] <= cfg_data;
        ocm_pkg::REG_SET_SIZE_3: set_size[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamped register values
  always_comb begin
    if (fft_len < ocm_pkg::FFT_W'(8)) begin
      eff_fft = ocm_pkg::FFT_W'(8);
    end else if (fft_len > ocm_pkg::FFT_W'(MAX_FFT_LEN)) begin
      eff_fft = ocm_pkg::FFT_W'(MAX_FFT_LEN);
    end else begin
      eff_fft = fft_len;
    end

    if (num_sets == '0) begin
      eff_sets = ocm_pkg::SETS_W'(1);
    end else if (num_sets > ocm_pkg::SETS_W'(SETS_LIM)) begin
      eff_sets = ocm_pkg::SETS_W'(SETS_LIM);
    end else begin
      eff_sets = num_sets;
    end

    size_raw = set_size[current_set];
    if (size_raw == '0) begin
      eff_size = ocm_pkg::FFT_W'(1);
    end else if (size_raw > eff_fft) begin
      eff_size = eff_fft;
    end else begin
      eff_size = size_raw;
    end
  end

  // hold the accepted beat
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_func <= func;
      item_data <= {sample_re, sample_im};
      item_eop  <= end_of_packet;
      item_set  <= table_set;
      item_slot <= table_slot;
      item_cidx <= carrier_index;
    end
  end

  // carrier table: read on accept at the next slot of the current set
  assign fc_in_range = (int'(filled_count) < MAX_FFT_LEN);
  assign tbl_raddr   = TBL_AW'(int'(current_set) * MAX_FFT_LEN + int'(filled_count));
  assign tbl_waddr   = TBL_AW'(int'(item_set) * MAX_FFT_LEN + int'(item_slot));

  // negative index counts from the top of the symbol
  always_comb begin
    if (item_cidx < 0) begin
      wrapped = {item_cidx[ocm_pkg::CIDX_W-1], item_cidx} + $signed({1'b0, eff_fft});
    end else begin
      wrapped = {item_cidx[ocm_pkg::CIDX_W-1], item_cidx};
    end
  end

  assign reject = wrapped[ocm_pkg::CIDX_W]
               || (wrapped[ocm_pkg::CIDX_W-1:0] >= eff_fft)
               || (int'(item_set) >= MAX_SETS)
               || (int'(item_slot) >= MAX_FFT_LEN);

  assign tbl_we = (state == ST_PROC) && (item_func == ocm_pkg::FUNC_TABLE) && !reject;

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= wrapped[BIN_W-1:0];
    end
    if (in_fire) begin
      tbl_rdata <= tbl_mem[tbl_raddr];
    end
  end

  // sample placement and symbol close
  assign fc_inc   = filled_count + 1'b1;
  assign bin_ok   = fc_in_range && (ocm_pkg::FFT_W'(tbl_rdata) < eff_fft);
  assign emit_now = (fc_inc >= eff_size) || item_eop;

  // next set: packet end or last set wraps to set zero
  always_comb begin
    if (item_eop || ({1'b0, current_set} + 1'b1 >= eff_sets)) begin
      current_set_next = '0;
    end else begin
      current_set_next = current_set + 1'b1;
    end
  end

  always_comb begin
    fcmd            = '0;
    fcmd.wr_bin     = ocm_pkg::BIN_NUM_W'(tbl_rdata);
    fcmd.wr_data    = item_data;
    fcmd.emit_len   = eff_fft;
    fcmd.emit_eop   = item_eop;
    if (state == ST_PROC && item_func == ocm_pkg::FUNC_DATA) begin
      fcmd.wr_en      = bin_ok;
      fcmd.emit_start = emit_now;
    end
    fcmd.rej_load = (state == ST_REJ) && fstat.fetch_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_set  <= '0;
      filled_count <= '0;
    end else if (state == ST_PROC && item_func == ocm_pkg::FUNC_DATA) begin
      if (emit_now) begin
        filled_count <= '0;
        current_set  <= current_set_next;
      end else begin
        filled_count <= fc_inc;
      end
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = ST_PROC;
        end
      end
      ST_PROC: begin
        if (item_func == ocm_pkg::FUNC_TABLE) begin
          state_next = reject ? ST_REJ : ST_IDLE;
        end else begin
          state_next = emit_now ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!fstat.emitting) begin
          state_next = ST_IDLE;
        end
      end
      ST_REJ: begin
        if (fstat.fetch_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // frame store, readout stage and output register
  ocm_frame #(
    .MAX_FFT_LEN (MAX_FFT_LEN)
  ) u_frame (
    .clk         (clk),
    .rst         (rst),
    .cmd         (fcmd),
    .stat        (fstat),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .bin_re      (bin_re),
    .bin_im      (bin_im),
    .bin_number  (bin_number),
    .last_bin    (last_bin),
    .packet_done (packet_done),
    .status      (status)
  );

  a_set_in_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, current_set} < ocm_pkg::SETS_W'(SETS_LIM)))
    else $error("current set beyond the set limit");

  a_emit_resets_fill: assert property (@(posedge clk) disable iff (rst)
    fcmd.emit_start |=> (filled_count == '0) && (state == ST_EMIT))
    else $error("fill count not cleared on symbol close");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    fstat.emitting |-> !in_ready)
    else $error("input taken during readout");

endmodule

`default_nettype wire

### design/ocm_frame.sv
// ----------------------------------------------------------------------------
// ocm_frame
// symbol store with per-bin valid bits, readout stage and output register
// ----------------------------------------------------------------------------
`default_nettype none

module ocm_frame #(
  parameter int MAX_FFT_LEN = ocm_pkg::DEF_MAX_FFT_LEN
) (
  input  wire                                    clk,
  input  wire                                    rst,
  input  wire ocm_pkg::frame_cmd_t               cmd,
  output ocm_pkg::frame_stat_t                   stat,
  input  wire                                    out_ready,
  output logic                                   out_valid,
  output logic signed [ocm_pkg::SAMPLE_W-1:0]    bin_re,
  output logic signed [ocm_pkg::SAMPLE_W-1:0]    bin_im,
  output logic        [ocm_pkg::BIN_NUM_W-1:0]   bin_number,
  output logic                                   last_bin,
  output logic                                   packet_done,
  output logic                                   status
);

  localparam int BIN_W = $clog2(MAX_FFT_LEN);

  logic [2*ocm_pkg::SAMPLE_W-1:0] frame_mem [MAX_FFT_LEN];
  logic [MAX_FFT_LEN-1:0]         used;

  logic             emitting;
  logic [BIN_W-1:0] issue_bin;
  logic [BIN_W-1:0] last_idx;
  logic             emit_eop;
  logic             issue_last;

  logic                           fetch_valid;
  logic [2*ocm_pkg::SAMPLE_W-1:0] fetch_data;
  logic                           fetch_used;
  logic [BIN_W-1:0]               fetch_bin;
  logic                           fetch_last;
  logic                           fetch_pkt;
  logic                           fetch_status;
  logic                           fetch_move;
  logic                           fetch_free;
  logic                           rd_en;

  assign issue_last = (issue_bin == last_idx);
  assign fetch_move = fetch_valid && (!out_valid || out_ready);
  assign fetch_free = !fetch_valid || fetch_move;
  assign rd_en      = emitting && fetch_free;

  assign stat.emitting   = emitting;
  assign stat.fetch_free = fetch_free;

  // store write and registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      frame_mem[cmd.wr_bin[BIN_W-1:0]] <= cmd.wr_data;
    end
    if (rd_en) begin
      fetch_data <= frame_mem[issue_bin];
    end
  end

  // valid bits: unused bins read as zero, cleared once the last bin is read
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (rd_en && issue_last) begin
      used <= '0;
    end else if (cmd.wr_en) begin
      used[cmd.wr_bin[BIN_W-1:0]] <= 1'b1;
    end
  end

  // readout counter
  always_ff @(posedge clk) begin
    if (rst) begin
      emitting  <= 1'b0;
      issue_bin <= '0;
    end else if (cmd.emit_start) begin
      emitting  <= 1'b1;
      issue_bin <= '0;
    end else if (rd_en) begin
      if (issue_last) begin
        emitting <= 1'b0;
      end
      issue_bin <= issue_bin + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_start) begin
      last_idx <= BIN_W'(cmd.emit_len - 1'b1);
      emit_eop <= cmd.emit_eop;
    end
  end

  // fetch stage
  always_ff @(posedge clk) begin
    if (rst) begin
      fetch_valid <= 1'b0;
    end else if (rd_en || cmd.rej_load) begin
      fetch_valid <= 1'b1;
    end else if (fetch_move) begin
      fetch_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fetch_used   <= used[issue_bin];
      fetch_bin    <= issue_bin;
      fetch_last   <= issue_last;
      fetch_pkt    <= issue_last && emit_eop;
      fetch_status <= 1'b0;
    end else if (cmd.rej_load) begin
      fetch_used   <= 1'b0;
      fetch_bin    <= '0;
      fetch_last   <= 1'b0;
      fetch_pkt    <= 1'b0;
      fetch_status <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fetch_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fetch_move) begin
      bin_re      <= fetch_used ? fetch_data[2*ocm_pkg::SAMPLE_W-1:ocm_pkg::SAMPLE_W] : '0;
      bin_im      <= fetch_used ? fetch_data[ocm_pkg::SAMPLE_W-1:0] : '0;
      bin_number  <= ocm_pkg::BIN_NUM_W'(fetch_bin);
      last_bin    <= fetch_last;
      packet_done <= fetch_pkt;
      status      <= fetch_status;
    end
  end

  a_no_write_while_emit: assert property (@(posedge clk) disable iff (rst)
    emitting |-> !cmd.wr_en)
    else $error("frame write during readout");

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    emitting |-> !cmd.emit_start)
    else $error("readout restarted while busy");

  a_rej_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.rej_load |-> (fetch_free && !emitting))
    else $error("status beat loaded into a busy fetch stage");

  a_cleared: assert property (@(posedge clk) disable iff (rst)
    (rd_en && issue_last) |=> (used == '0))
    else $error("frame store not cleared after readout");

endmodule

`default_nettype wire

### tb/ofdm_carrier_mapper_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofdm_carrier_mapper_tb
// self-checking bench: carrier table loads, sample placement and symbol
// readout are predicted beat by beat and compared with every output bin
// ----------------------------------------------------------------------------

module ofdm_carrier_mapper_tb;

  localparam int MAX_BINS        = ocm_pkg::DEF_MAX_FFT_LEN;
  localparam int SET_SLOTS       = ocm_pkg::DEF_MAX_SETS;
  localparam int TABLE_DEPTH     = SET_SLOTS * MAX_BINS;
  localparam int RAND_PHASES     = 6;
  localparam int BEATS_PER_PHASE = 48;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT  = 3000;

  // one input beat, all fields kept even where func makes them don't-care
  typedef struct {
    logic                                func;
    logic signed [ocm_pkg::SAMPLE_W-1:0] re;
    logic signed [ocm_pkg::SAMPLE_W-1:0] im;
    logic                                eop;
    logic [ocm_pkg::TSET_W-1:0]          tset;
    logic [ocm_pkg::SLOT_W-1:0]          slot;
    logic signed [ocm_pkg::CIDX_W-1:0]   cidx;
  } in_beat_t;

  // one output beat
  typedef struct {
    logic signed [ocm_pkg::SAMPLE_W-1:0] re;
    logic signed [ocm_pkg::SAMPLE_W-1:0] im;
    logic [ocm_pkg::BIN_NUM_W-1:0]       number;
    logic                                last;
    logic                                done;
    logic                                status;
  } bin_beat_t;

  // receiver stall patterns, cycled through over time
  typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_THREE_OF_FOUR, RDY_SPARSE} rdy_mode_t;

  // ---------------------------------------------------------------------------
  // block signals, all inputs known from time zero
  // ---------------------------------------------------------------------------
  logic                                clk           = 1'b0;
  logic                                rst           = 1'b1;
  logic                                cfg_write     = 1'b0;
  logic [ocm_pkg::REG_IDX_W-1:0]       cfg_index     = '0;
  logic [ocm_pkg::CFG_W-1:0]           cfg_data      = '0;
  logic                                in_valid      = 1'b0;
  logic                                in_ready;
  logic                                func          = ocm_pkg::FUNC_DATA;
  logic signed [ocm_pkg::SAMPLE_W-1:0] sample_re     = '0;
  logic signed [ocm_pkg::SAMPLE_W-1:0] sample_im     = '0;
  logic                                end_of_packet = 1'b0;
  logic [ocm_pkg::TSET_W-1:0]          table_set     = '0;
  logic [ocm_pkg::SLOT_W-1:0]          table_slot    = '0;
  logic signed [ocm_pkg::CIDX_W-1:0]   carrier_index = '0;
  logic                                out_valid;
  logic                                out_ready     = 1'b0;
  logic signed [ocm_pkg::SAMPLE_W-1:0] bin_re;
  logic signed [ocm_pkg::SAMPLE_W-1:0] bin_im;
  logic [ocm_pkg::BIN_NUM_W-1:0]       bin_number;
  logic                                last_bin;
  logic                                packet_done;
  logic                                status;

  ofdm_carrier_mapper i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .func          (func),
    .sample_re     (sample_re),
    .sample_im     (sample_im),
    .end_of_packet (end_of_packet),
    .table_set     (table_set),
    .table_slot    (table_slot),
    .carrier_index (carrier_index),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .bin_re        (bin_re),
    .bin_im        (bin_im),
    .bin_number    (bin_number),
    .last_bin      (last_bin),
    .packet_done   (packet_done),
    .status        (status)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor state: register shadow, carrier table, symbol under assembly
  // ---------------------------------------------------------------------------
  logic [ocm_pkg::CFG_W-1:0]        reg_val [6];
  logic [ocm_pkg::BIN_NUM_W-1:0]    carrier_map [TABLE_DEPTH];
  logic [2*ocm_pkg::SAMPLE_W-1:0]   symbol_bins [MAX_BINS];
  int                               sym_set;
  int                               sym_fill;

  bin_beat_t               bins_due [$];       // expected output beats, oldest first
  in_beat_t                beats_to_send [$];  // stimulus not yet handed to the driver

  // stimulus side bookkeeping so that no unwritten table entry is ever read
  bit                      slot_loaded [TABLE_DEPTH];
  int                      gen_set;
  int                      gen_fill;

  // run statistics and error count
  int                      n_beats   = 0;
  int                      n_table   = 0;
  int                      n_rejects = 0;
  int                      n_symbols = 0;
  int                      n_bins    = 0;
  int                      n_errors  = 0;
  bit                      hold_request = 1'b0;

  // effective bin count of a symbol, clamped
  function automatic int bins_per_symbol();
    int v;
    v = reg_val[ocm_pkg::REG_FFT_LEN];
    if (v < 8) return 8;
    if (v > MAX_BINS) return MAX_BINS;
    return v;
  endfunction

  function automatic int sets_in_use();
    int v;
    int lim;
    v   = reg_val[ocm_pkg::REG_NUM_SETS];
    lim = (SET_SLOTS < ocm_pkg::NUM_SIZES) ? SET_SLOTS : ocm_pkg::NUM_SIZES;
    if (v < 1) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  // data carriers of one set, clamped to the bin count
  function automatic int set_capacity(int s);
    int v;
    int f;
    v = reg_val[ocm_pkg::REG_SET_SIZE_0 + (s % ocm_pkg::NUM_SIZES)];
    f = bins_per_symbol();
    if (v < 1) return 1;
    if (v > f) return f;
    return v;
  endfunction

  // set that follows a finished symbol; a packet end restarts at set zero
  function automatic int set_after(int s, logic eop);
    return (eop || s + 1 >= sets_in_use()) ? 0 : s + 1;
  endfunction

  // predicted effect of one accepted beat
  task automatic map_to_bins(input in_beat_t b);
    int        f;
    int        ci;
    int        cs;
    int        bin;
    bin_beat_t r;
    f = bins_per_symbol();
    if (b.func == ocm_pkg::FUNC_TABLE) begin
      ci = b.cidx;
      if (ci < 0) ci += f;
      if (ci < 0 || ci >= f) begin
        // rejected write: a single status beat, table untouched
        r.re     = '0;
        r.im     = '0;
        r.number = '0;
        r.last   = 1'b0;
        r.done   = 1'b0;
        r.status = 1'b1;
        bins_due.push_back(r);
        n_rejects++;
      end else begin
        carrier_map[int'(b.tset) * MAX_BINS + int'(b.slot)] = ci[ocm_pkg::BIN_NUM_W-1:0];
      end
    end else begin
      cs = sym_set % SET_SLOTS;
      if (sym_fill < MAX_BINS) begin
        bin = carrier_map[cs * MAX_BINS + sym_fill];
        // a bin left over from a larger symbol size is dropped
        if (bin < f) symbol_bins[bin] = {b.re, b.im};
      end
      sym_fill++;
      if (sym_fill >= set_capacity(cs) || b.eop) begin
        for (int k = 0; k < f; k++) begin
          r.re     = symbol_bins[k][2*ocm_pkg::SAMPLE_W-1:ocm_pkg::SAMPLE_W];
          r.im     = symbol_bins[k][ocm_pkg::SAMPLE_W-1:0];
          r.number = k[ocm_pkg::BIN_NUM_W-1:0];
          r.last   = (k == f - 1);
          r.done   = (k == f - 1) && b.eop;
          r.status = 1'b0;
          bins_due.push_back(r);
        end
        foreach (symbol_bins[k]) symbol_bins[k] = '0;
        sym_fill = 0;
        sym_set  = set_after(sym_set, b.eop);
        n_symbols++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic in_beat_t random_beat();
    in_beat_t b;
    b.func = 1'($urandom_range(0, 1));
    b.re   = ocm_pkg::SAMPLE_W'($urandom);
    b.im   = ocm_pkg::SAMPLE_W'($urandom);
    b.eop  = 1'($urandom_range(0, 1));
    b.tset = ocm_pkg::TSET_W'($urandom);
    b.slot = ocm_pkg::SLOT_W'($urandom);
    b.cidx = ocm_pkg::CIDX_W'($urandom);
    return b;
  endfunction

  task automatic queue_table(input int set_no, input int slot_no, input int ci);
    in_beat_t b;
    int       f;
    int       w;
    b      = random_beat();
    b.func = ocm_pkg::FUNC_TABLE;
    b.tset = ocm_pkg::TSET_W'(set_no);
    b.slot = ocm_pkg::SLOT_W'(slot_no);
    b.cidx = ocm_pkg::CIDX_W'(ci);
    f = bins_per_symbol();
    w = (ci < 0) ? ci + f : ci;
    if (w >= 0 && w < f) slot_loaded[set_no * MAX_BINS + slot_no] = 1'b1;
    beats_to_send.push_back(b);
  endtask

  // a data sample; the slot it will read is loaded first if it never was
  task automatic queue_sample(input logic signed [ocm_pkg::SAMPLE_W-1:0] re,
                              input logic signed [ocm_pkg::SAMPLE_W-1:0] im,
                              input logic eop);
    in_beat_t b;
    int       f;
    f = bins_per_symbol();
    if (gen_fill < MAX_BINS && !slot_loaded[gen_set * MAX_BINS + gen_fill])
      queue_table(gen_set, gen_fill, int'($urandom_range(0, 2 * f - 1)) - f);
    b      = random_beat();
    b.func = ocm_pkg::FUNC_DATA;
    b.re   = re;
    b.im   = im;
    b.eop  = eop;
    beats_to_send.push_back(b);
    gen_fill++;
    if (gen_fill >= set_capacity(gen_set) || eop) begin
      gen_fill = 0;
      gen_set  = set_after(gen_set, eop);
    end
  endtask

  // mostly samples with random content, some table writes of any index
  task automatic queue_random_beat();
    if ($urandom_range(0, 99) < 15)
      queue_table($urandom_range(0, SET_SLOTS - 1), $urandom_range(0, MAX_BINS - 1),
                  int'($urandom_range(0, 127)) - 64);
    else
      queue_sample(ocm_pkg::SAMPLE_W'($urandom), ocm_pkg::SAMPLE_W'($urandom),
                   $urandom_range(0, 11) == 0);
  endtask

  // register write at idle, shadow updated alongside
  task automatic write_reg(input logic [ocm_pkg::REG_IDX_W-1:0] idx, input int val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[ocm_pkg::CFG_W-1:0];
    reg_val[idx] = (idx == ocm_pkg::REG_NUM_SETS) ?
                   ocm_pkg::CFG_W'(val[ocm_pkg::SETS_W-1:0]) : val[ocm_pkg::CFG_W-1:0];
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic program_regs(input int fft, input int sets,
                              input int s0, input int s1, input int s2, input int s3);
    write_reg(ocm_pkg::REG_FFT_LEN, fft);
    write_reg(ocm_pkg::REG_NUM_SETS, sets);
    write_reg(ocm_pkg::REG_SET_SIZE_0, s0);
    write_reg(ocm_pkg::REG_SET_SIZE_1, s1);
    write_reg(ocm_pkg::REG_SET_SIZE_2, s2);
    write_reg(ocm_pkg::REG_SET_SIZE_3, s3);
  endtask

  // wait until every queued beat went in and every predicted bin came out,
  // then give a trailing table write time to land
  task automatic drain();
    do @(negedge clk);
    while (beats_to_send.size() != 0 || in_valid || bins_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // driver: bursts of random length, random gaps, payload held until taken
  // ---------------------------------------------------------------------------
  in_beat_t beat_now;
  int       burst_left = 1;
  int       gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      // beat taken at this edge: predict it now
      if (in_valid && in_ready) begin
        map_to_bins(beat_now);
        n_beats++;
        if (beat_now.func == ocm_pkg::FUNC_TABLE) n_table++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (beats_to_send.size() != 0) begin
          beat_now = beats_to_send.pop_front();
          func          <= beat_now.func;
          sample_re     <= beat_now.re;
          sample_im     <= beat_now.im;
          end_of_packet <= beat_now.eop;
          table_set     <= beat_now.tset;
          table_slot    <= beat_now.slot;
          carrier_index <= beat_now.cidx;
          in_valid      <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: compares each output beat with the oldest predicted bin
  // ---------------------------------------------------------------------------
  bin_beat_t bin_want;
  int        ready_tick = 0;
  int        hold_left  = 0;
  bit        hold_done  = 1'b0;
  rdy_mode_t rdy_mode;

  function automatic void check_field(string name, logic signed [31:0] want_v,
                                      logic signed [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      n_errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (bins_due.size() == 0) begin
        $error("output beat with nothing expected: bin_number %0d status %0d",
               bin_number, status);
        n_errors++;
      end else begin
        bin_want = bins_due.pop_front();
        check_field("bin_re", bin_want.re, bin_re);
        check_field("bin_im", bin_want.im, bin_im);
        check_field("bin_number", bin_want.number, bin_number);
        check_field("last_bin", bin_want.last, last_bin);
        check_field("packet_done", bin_want.done, packet_done);
        check_field("status", bin_want.status, status);
      end
      n_bins++;
    end

    // one long hold-off while the sender keeps pushing, so the input backs up
    if (hold_request && !hold_done && out_valid) begin
      hold_done = 1'b1;
      hold_left = HOLD_OFF_CYCLES;
    end

    ready_tick++;
    rdy_mode = rdy_mode_t'((ready_tick / 96) % 4);
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (rdy_mode)
        RDY_ALWAYS:        out_ready <= 1'b1;
        RDY_COIN:          out_ready <= 1'($urandom_range(0, 1));
        RDY_THREE_OF_FOUR: out_ready <= (ready_tick % 4) != 0;
        default:           out_ready <= $urandom_range(0, 4) == 0;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long without a beat on either channel ends the run
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("stalled for %0d cycles, %0d beats still queued, %0d bins still due",
             WATCHDOG_LIMIT, beats_to_send.size(), bins_due.size());
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus: directed part, then random phases under changing registers
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int p;
    // shadow state as after reset
    reg_val[ocm_pkg::REG_FFT_LEN]    = ocm_pkg::RST_FFT_LEN;
    reg_val[ocm_pkg::REG_NUM_SETS]   = ocm_pkg::CFG_W'(ocm_pkg::RST_NUM_SETS);
    reg_val[ocm_pkg::REG_SET_SIZE_0] = ocm_pkg::RST_SET_SIZE;
    reg_val[ocm_pkg::REG_SET_SIZE_1] = ocm_pkg::RST_SET_SIZE;
    reg_val[ocm_pkg::REG_SET_SIZE_2] = ocm_pkg::RST_SET_SIZE;
    reg_val[ocm_pkg::REG_SET_SIZE_3] = ocm_pkg::RST_SET_SIZE;
    foreach (carrier_map[k]) carrier_map[k] = '0;
    foreach (symbol_bins[k]) symbol_bins[k] = '0;
    sym_set  = 0;
    sym_fill = 0;
    gen_set  = 0;
    gen_fill = 0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // bin count below the minimum clamps to 8; only sets zero and one are in use
    program_regs(0, 2, 3, 2, 0, 127);

    queue_table(0, 0, -8);     // wraps to bin 0
    queue_table(0, 1, 7);      // top bin
    queue_table(0, 2, -1);     // wraps onto the top bin as well
    queue_table(0, 3, 8);      // one past the top: rejected
    queue_table(0, 3, -9);     // still negative after wrapping: rejected
    queue_table(3, 63, 63);    // largest index, last set and slot: rejected
    queue_table(2, 0, -64);    // smallest index: rejected
    queue_table(1, 0, 3);
    queue_table(1, 1, 4);
    queue_sample(16'sh7fff, 16'sh8000, 1'b0);
    queue_sample(16'sh8000, 16'sh7fff, 1'b0);
    queue_sample(16'sh0000, 16'sh0000, 1'b0);   // set zero full
    queue_sample(16'sh0001, 16'shffff, 1'b0);
    queue_sample(16'shfffe, 16'sh0002, 1'b0);   // set one full, wraps to set zero
    queue_sample(16'sh0005, 16'sh0006, 1'b1);   // packet ends mid-set
    queue_sample(16'sh0007, 16'sh0008, 1'b1);   // one-sample packet
    drain();

    for (p = 0; p < RAND_PHASES; p++) begin
      case (p)
        // above the maximum clamps to 64 bins and 4 sets
        0: program_regs(127, 7, 64, 1, 9, 33);
        // smaller symbol: table entries loaded for 64 bins may go stale
        1: program_regs(16, 3, 0, 5, 16, 127);
        // exact minimum, every sample closes a symbol
        2: program_regs(8, 1, 1, $urandom_range(0, 127), $urandom_range(0, 127),
                        $urandom_range(0, 127));
        default: program_regs($urandom_range(0, 127), $urandom_range(0, 7),
                              $urandom_range(0, 1) ? $urandom_range(1, 8) : $urandom_range(0, 127),
                              $urandom_range(0, 1) ? $urandom_range(1, 8) : $urandom_range(0, 127),
                              $urandom_range(0, 1) ? $urandom_range(1, 8) : $urandom_range(0, 127),
                              $urandom_range(0, 1) ? $urandom_range(1, 8) : $urandom_range(0, 127));
      endcase
      repeat (BEATS_PER_PHASE) queue_random_beat();
      if (p == 0) hold_request = 1'b1;
      drain();
    end

    $display("%0d input beats (%0d table writes, %0d rejected), %0d symbols, %0d bins checked",
             n_beats, n_table, n_rejects, n_symbols, n_bins);
    $display("register settings covered both clamps of bin count, set count and set sizes");
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
